// ----- rtl/core/lse_pkg.sv -----
// Shared types, constants and datapath step functions for the Slater exchange unit.
// No dependencies; every other file in rtl/core refers to it by scoped names.
package lse_pkg;

   localparam int RHO_W        = 48;
   localparam int ROOT_W       = 43;
   localparam int CBRT_STAGES  = 43;
   localparam int CBRT_REM_W   = 90;
   localparam int SH_W         = 87;
   localparam int DIV_W        = 50;
   localparam int QUO_W        = 63;
   localparam int DIV_STAGES   = 63;
   localparam int CSR_IDX_W    = 1;

   localparam logic [32:0] CBRT_SIX_OVER_PI = 33'd5328770141;
   localparam logic [31:0] SCALE_RESET      = 32'h1000_0000;
   localparam logic [63:0] SAT_MAX          = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] SAT_MIN          = 64'h8000_0000_0000_0000;

   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_FACTOR = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SPIN_MODE    = 1'b1;

   localparam logic KIND_ENERGY = 1'b0;
   localparam logic KIND_HESS   = 1'b1;

   typedef struct packed {
      logic               kind;
      logic [47:0]        rho_alpha;
      logic [47:0]        rho_beta;
      logic signed [63:0] prior_energy;
      logic signed [63:0] prior_grad_alpha;
      logic signed [63:0] prior_grad_beta;
      logic signed [63:0] prior_hess_aa;
      logic signed [63:0] prior_hess_bb;
   } req_type;

   typedef struct packed {
      logic signed [63:0] energy_out;
      logic signed [63:0] grad_alpha_out;
      logic signed [63:0] grad_beta_out;
      logic signed [63:0] hess_aa_out;
      logic signed [63:0] hess_bb_out;
      logic               saturated;
   } rsp_type;

   typedef struct packed {
      logic [CBRT_REM_W-1:0] rem;
      logic [ROOT_W-1:0]     root;
      logic [2*ROOT_W-1:0]   sq;
   } cbrt_type;

   typedef struct packed {
      logic [DIV_W-1:0] rem;
      logic [QUO_W-1:0] quo;
   } div_type;

   typedef struct packed {
      logic [63:0] value;
      logic        clip;
   } sat_type;

   // One radix-8 digit of the cube root; root squared is kept so no multiply is needed.
   function automatic cbrt_type cbrt_step(cbrt_type s, logic [2:0] bits);
      logic [CBRT_REM_W+2:0] acc;
      logic [CBRT_REM_W+2:0] test;
      cbrt_type              r;
      acc  = {s.rem, bits};
      test = ({7'b0, s.sq} << 3) + ({7'b0, s.sq} << 2)
           + ({50'b0, s.root} << 2) + ({50'b0, s.root} << 1) + 93'd1;
      if (acc >= test) begin
         r.rem  = CBRT_REM_W'(acc - test);
         r.root = {s.root[ROOT_W-2:0], 1'b1};
         r.sq   = {s.sq[2*ROOT_W-3:0], 2'b00} + {41'b0, s.root, 2'b00} + 86'd1;
      end else begin
         r.rem  = CBRT_REM_W'(acc);
         r.root = {s.root[ROOT_W-2:0], 1'b0};
         r.sq   = {s.sq[2*ROOT_W-3:0], 2'b00};
      end
      return r;
   endfunction

   // One restoring division step, one quotient bit.
   function automatic div_type div_step(div_type s, logic bit_in, logic [DIV_W-1:0] den);
      logic [DIV_W:0] acc;
      div_type        r;
      acc   = {s.rem, bit_in};
      r.quo = {s.quo[QUO_W-2:0], 1'b0};
      if (acc >= {1'b0, den}) begin
         r.rem    = DIV_W'(acc - {1'b0, den});
         r.quo[0] = 1'b1;
      end else begin
         r.rem = DIV_W'(acc);
      end
      return r;
   endfunction

   // Signed accumulate with clipping; big forces the end in the term's direction.
   function automatic sat_type sat_add(logic [63:0] prior, logic [63:0] mag, logic neg,
                                       logic big);
      logic [63:0] term;
      logic [63:0] sum;
      sat_type     r;
      term    = neg ? (~mag + 64'd1) : mag;
      sum     = prior + term;
      r.value = sum;
      r.clip  = 1'b0;
      if (big) begin
         r.clip  = 1'b1;
         r.value = neg ? SAT_MIN : SAT_MAX;
      end else if (prior[63] == term[63] && prior[63] != sum[63]) begin
         r.clip  = 1'b1;
         r.value = prior[63] ? SAT_MIN : SAT_MAX;
      end
      return r;
   endfunction

endpackage

// ----- rtl/core/lse_cbrt.sv -----
// Pipelined digit-by-digit cube root, floor(cbrt(rho * 2^80)), one digit per stage.
// Depends on lse_pkg.
module lse_cbrt (
   input  logic                          clock,
   input  logic [lse_pkg::RHO_W-1:0]     rho_in,
   output logic [lse_pkg::ROOT_W-1:0]    root_out
);
   localparam int RAD_W = 3 * lse_pkg::CBRT_STAGES;
   localparam int PAD_W = RAD_W - lse_pkg::RHO_W - 1;

   logic [lse_pkg::RHO_W-1:0] rho_ff   [lse_pkg::CBRT_STAGES];
   logic [lse_pkg::RHO_W-1:0] rho_src  [lse_pkg::CBRT_STAGES];
   lse_pkg::cbrt_type         stage_ff [lse_pkg::CBRT_STAGES];
   lse_pkg::cbrt_type         prev_src [lse_pkg::CBRT_STAGES];

   for (genvar i = 0; i < lse_pkg::CBRT_STAGES; i++) begin : g_stage
      localparam int TOP = RAD_W - 1 - 3 * i;
      logic [RAD_W-1:0] rad;
      if (i == 0) begin : g_first
         assign rho_src[i]  = rho_in;
         assign prev_src[i] = '0;
      end else begin : g_next
         assign rho_src[i]  = rho_ff[i-1];
         assign prev_src[i] = stage_ff[i-1];
      end
      assign rad = {1'b0, rho_src[i], {PAD_W{1'b0}}};
      always_ff @(posedge clock) begin
         rho_ff[i]   <= rho_src[i];
         stage_ff[i] <= lse_pkg::cbrt_step(prev_src[i], rad[TOP -: 3]);
      end
   end

   assign root_out = stage_ff[lse_pkg::CBRT_STAGES-1].root;
endmodule

// ----- rtl/core/lse_div.sv -----
// Pipelined restoring divider for the Hessian term, one quotient bit per stage.
// Depends on lse_pkg; quotient valid only when num < den * 2^63 and den is nonzero.
module lse_div (
   input  logic                         clock,
   input  logic [lse_pkg::SH_W-1:0]     num,
   input  logic [lse_pkg::DIV_W-1:0]    den,
   output logic [lse_pkg::QUO_W-1:0]    quo
);
   localparam int HEAD_W = lse_pkg::SH_W - lse_pkg::QUO_W;

   logic [lse_pkg::QUO_W-1:0] low_ff   [lse_pkg::DIV_STAGES];
   logic [lse_pkg::QUO_W-1:0] low_src  [lse_pkg::DIV_STAGES];
   logic [lse_pkg::DIV_W-1:0] den_ff   [lse_pkg::DIV_STAGES];
   logic [lse_pkg::DIV_W-1:0] den_src  [lse_pkg::DIV_STAGES];
   lse_pkg::div_type          stage_ff [lse_pkg::DIV_STAGES];
   lse_pkg::div_type          prev_src [lse_pkg::DIV_STAGES];

   for (genvar i = 0; i < lse_pkg::DIV_STAGES; i++) begin : g_stage
      if (i == 0) begin : g_first
         assign low_src[i]       = num[lse_pkg::QUO_W-1:0];
         assign den_src[i]       = den;
         assign prev_src[i].rem  = {{(lse_pkg::DIV_W-HEAD_W){1'b0}},
                                    num[lse_pkg::SH_W-1:lse_pkg::QUO_W]};
         assign prev_src[i].quo  = '0;
      end else begin : g_next
         assign low_src[i]  = low_ff[i-1];
         assign den_src[i]  = den_ff[i-1];
         assign prev_src[i] = stage_ff[i-1];
      end
      always_ff @(posedge clock) begin
         low_ff[i]   <= low_src[i];
         den_ff[i]   <= den_src[i];
         stage_ff[i] <= lse_pkg::div_step(prev_src[i], low_src[i][lse_pkg::QUO_W-1-i],
                                          den_src[i]);
      end
   end

   assign quo = stage_ff[lse_pkg::DIV_STAGES-1].quo;
endmodule

// ----- rtl/core/lda_slater_exchange_point_unit.sv -----
// Top level of the Slater (LDA) exchange unit: one grid point per cycle, fixed point.
// Depends on lse_pkg, lse_cbrt and lse_div.
//
//   channel   ports                             transfer
//   -------   -------------------------------   -----------------------------------
//   request   start, busy, req_data             edge with start high and busy low
//   result    rsp_strobe, rsp_data              edge ending the strobe cycle
//   csr       csr_valid, csr_ready, csr_index,  edge with csr_valid and csr_ready
//             csr_data
//
// A new point enters every cycle; busy stays low. Results come out in order. The depth
// is set by the 43-stage cube root followed by the 63-stage Hessian divider plus the
// multiply and clip stages.
// Synchronous reset clears the stage valid bits and spin mode; scale gets SCALE_RESET.
// The receiver cannot stall, so the pipeline advances every cycle.
module lda_slater_exchange_point_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  lse_pkg::req_type                  req_data,
   output logic                              rsp_strobe,
   output lse_pkg::rsp_type                  rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [lse_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [31:0]                       csr_data
);
   // Stage map, index into the point pipeline
   localparam int STAGE_MUL    = lse_pkg::CBRT_STAGES + 1;
   localparam int STAGE_PROD   = STAGE_MUL + 1;
   localparam int STAGE_GRAD   = STAGE_PROD + 1;
   localparam int STAGE_ENERGY = STAGE_GRAD + 3;
   localparam int STAGE_HESS   = STAGE_GRAD + lse_pkg::DIV_STAGES;
   localparam int PIPE_DEPTH   = STAGE_HESS + 1;
   localparam int SPIN_A       = 0;
   localparam int SPIN_B       = 1;

   typedef struct packed {
      logic        valid;
      logic        kind;
      logic        use_a;
      logic        use_b;
      logic [47:0] rho_a;
      logic [47:0] rho_b;
      logic [63:0] energy;
      logic [63:0] grad_a;
      logic [63:0] grad_b;
      logic [63:0] hess_aa;
      logic [63:0] hess_bb;
      logic        flag;
      logic        big_a;
      logic        big_b;
      logic        zero_a;
      logic        zero_b;
   } pipe_type;

   // Configuration registers and the derived weight |g| * 2^60
   logic [31:0] scale_ff;
   logic [1:0]  spin_ff;
   logic [63:0] m_ff;
   logic        neg_ff;
   logic        m_zero_ff;
   logic [31:0] scale_abs;
   logic [64:0] m_full;

   pipe_type pipe_ff [PIPE_DEPTH];
   pipe_type pipe_in [PIPE_DEPTH];

   // Per-spin results of the root, multiply and divide units
   logic [50:0]  p_sp    [2];
   logic [106:0] g_sp    [2];
   logic [62:0]  q_sp    [2];
   logic         big_sp  [2];
   logic         zero_sp [2];

   // Energy path registers
   logic [51:0]  s_sum;
   logic [53:0]  s3_ff;
   logic [58:0]  e_ll_ff;
   logic [58:0]  e_lh_ff;
   logic [58:0]  e_hl_ff;
   logic [58:0]  e_hh_ff;
   logic [117:0] e_ff;

   lse_pkg::sat_type ga_sat;
   lse_pkg::sat_type gb_sat;
   lse_pkg::sat_type e_sat;
   lse_pkg::sat_type ha_sat;
   lse_pkg::sat_type hb_sat;

   logic do_ga, do_gb, do_e, do_ha, do_hb;

   // Hessian update: zero density goes to the end in the direction of g,
   // or holds the prior when g is zero.
   function automatic lse_pkg::sat_type hess_pick(logic [63:0] prior, logic [62:0] q,
                                                  logic neg, logic big, logic zero,
                                                  logic m_zero);
      lse_pkg::sat_type r;
      if (zero) begin
         r.clip  = 1'b1;
         r.value = m_zero ? prior : (neg ? lse_pkg::SAT_MIN : lse_pkg::SAT_MAX);
      end else begin
         r = lse_pkg::sat_add(prior, {1'b0, q}, neg, big);
      end
      return r;
   endfunction

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   // Take csr writes; the user must issue them only while no point is in flight; the block does not enforce this.
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= lse_pkg::SCALE_RESET;
         spin_ff  <= 2'b00;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            lse_pkg::CSR_SCALE_FACTOR: scale_ff <= csr_data;
            lse_pkg::CSR_SPIN_MODE:    spin_ff  <= csr_data[1:0];
         endcase
      end
   end

   // Precompute m = |scale| * K; used only after the cube root, so the lag is hidden.
   assign scale_abs = scale_ff[31] ? (~scale_ff + 32'd1) : scale_ff;
   assign m_full    = {33'b0, scale_abs} * {32'b0, lse_pkg::CBRT_SIX_OVER_PI};

   always_ff @(posedge clock) begin
      m_ff      <= m_full[63:0];
      neg_ff    <= (scale_ff != 32'd0) && !scale_ff[31];
      m_zero_ff <= (scale_ff == 32'd0);
   end

   // Per-spin datapath: cube root, products rho*f and m*f, then the divider.
   for (genvar s = 0; s < 2; s++) begin : g_spin
      logic [47:0]  rho_root;
      logic [47:0]  rho_mul;
      logic [47:0]  rho_prod;
      logic [42:0]  root;
      logic [49:0]  den;
      logic [45:0]  rf_ll_ff;
      logic [44:0]  rf_lh_ff;
      logic [45:0]  rf_hl_ff;
      logic [44:0]  rf_hh_ff;
      logic [53:0]  mf_ll_ff;
      logic [52:0]  mf_lh_ff;
      logic [53:0]  mf_hl_ff;
      logic [52:0]  mf_hh_ff;
      logic [90:0]  rf_ff;
      logic [106:0] mf_ff;

      assign rho_root = (s == SPIN_A) ? pipe_ff[0].rho_a : pipe_ff[0].rho_b;
      assign rho_mul  = (s == SPIN_A) ? pipe_ff[STAGE_MUL-1].rho_a
                                      : pipe_ff[STAGE_MUL-1].rho_b;
      assign rho_prod = (s == SPIN_A) ? pipe_ff[STAGE_PROD].rho_a
                                      : pipe_ff[STAGE_PROD].rho_b;

      lse_cbrt u_cbrt (
         .clock    (clock),
         .rho_in   (rho_root),
         .root_out (root)
      );

      // Split into partial products, then sum in the next stage.
      always_ff @(posedge clock) begin
         rf_ll_ff <= rho_mul[23:0]  * root[21:0];
         rf_lh_ff <= rho_mul[23:0]  * root[42:22];
         rf_hl_ff <= rho_mul[47:24] * root[21:0];
         rf_hh_ff <= rho_mul[47:24] * root[42:22];
         mf_ll_ff <= m_ff[31:0]  * root[21:0];
         mf_lh_ff <= m_ff[31:0]  * root[42:22];
         mf_hl_ff <= m_ff[63:32] * root[21:0];
         mf_hh_ff <= m_ff[63:32] * root[42:22];
         rf_ff    <= 91'(rf_ll_ff) + (91'(rf_lh_ff) << 22)
                   + (91'(rf_hl_ff) << 24) + (91'(rf_hh_ff) << 46);
         mf_ff    <= 107'(mf_ll_ff) + (107'(mf_lh_ff) << 22)
                   + (107'(mf_hl_ff) << 32) + (107'(mf_hh_ff) << 54);
      end

      assign den = ({2'b00, rho_prod} << 1) + {2'b00, rho_prod};

      lse_div u_div (
         .clock (clock),
         .num   (mf_ff[106:20]),
         .den   (den),
         .quo   (q_sp[s])
      );

      assign p_sp[s]    = rf_ff[90:40];
      assign g_sp[s]    = mf_ff;
      // Quotient of 2^63 or more is known from the top numerator bits alone.
      assign big_sp[s]  = {26'b0, mf_ff[106:83]} >= den;
      assign zero_sp[s] = (rho_prod == 48'd0);
   end

   // Energy path: 3 * sum of selected rho^(4/3), times m, in split products.
   assign s_sum = (pipe_ff[STAGE_PROD].use_a ? {1'b0, p_sp[SPIN_A]} : 52'd0)
                + (pipe_ff[STAGE_PROD].use_b ? {1'b0, p_sp[SPIN_B]} : 52'd0);

   always_ff @(posedge clock) begin
      s3_ff   <= ({2'b00, s_sum} << 1) + {2'b00, s_sum};
      e_ll_ff <= m_ff[31:0]  * s3_ff[26:0];
      e_lh_ff <= m_ff[31:0]  * s3_ff[53:27];
      e_hl_ff <= m_ff[63:32] * s3_ff[26:0];
      e_hh_ff <= m_ff[63:32] * s3_ff[53:27];
      e_ff    <= 118'(e_ll_ff) + (118'(e_lh_ff) << 27)
               + (118'(e_hl_ff) << 32) + (118'(e_hh_ff) << 59);
   end

   // Clip stages
   assign do_ga = pipe_ff[STAGE_GRAD-1].kind == lse_pkg::KIND_ENERGY
                  && pipe_ff[STAGE_GRAD-1].use_a;
   assign do_gb = pipe_ff[STAGE_GRAD-1].kind == lse_pkg::KIND_ENERGY
                  && pipe_ff[STAGE_GRAD-1].use_b;
   assign do_e  = pipe_ff[STAGE_ENERGY-1].kind == lse_pkg::KIND_ENERGY
                  && (pipe_ff[STAGE_ENERGY-1].use_a || pipe_ff[STAGE_ENERGY-1].use_b);
   assign do_ha = pipe_ff[STAGE_HESS-1].kind == lse_pkg::KIND_HESS
                  && pipe_ff[STAGE_HESS-1].use_a;
   assign do_hb = pipe_ff[STAGE_HESS-1].kind == lse_pkg::KIND_HESS
                  && pipe_ff[STAGE_HESS-1].use_b;

   assign ga_sat = lse_pkg::sat_add(pipe_ff[STAGE_GRAD-1].grad_a,
                                    {17'b0, g_sp[SPIN_A][106:60]}, neg_ff, 1'b0);
   assign gb_sat = lse_pkg::sat_add(pipe_ff[STAGE_GRAD-1].grad_b,
                                    {17'b0, g_sp[SPIN_B][106:60]}, neg_ff, 1'b0);
   assign e_sat  = lse_pkg::sat_add(pipe_ff[STAGE_ENERGY-1].energy,
                                    {8'b0, e_ff[117:62]}, neg_ff, 1'b0);
   assign ha_sat = hess_pick(pipe_ff[STAGE_HESS-1].hess_aa, q_sp[SPIN_A], neg_ff,
                             pipe_ff[STAGE_HESS-1].big_a, pipe_ff[STAGE_HESS-1].zero_a,
                             m_zero_ff);
   assign hb_sat = hess_pick(pipe_ff[STAGE_HESS-1].hess_bb, q_sp[SPIN_B], neg_ff,
                             pipe_ff[STAGE_HESS-1].big_b, pipe_ff[STAGE_HESS-1].zero_b,
                             m_zero_ff);

   // Advance every stage; update fields in place at their stage.
   // Drop valid bits on reset; payload needs none.
   always_comb begin
      pipe_in[0].valid   = start && !busy && !reset;
      pipe_in[0].kind    = req_data.kind;
      pipe_in[0].use_a   = !spin_ff[0];
      pipe_in[0].use_b   = !spin_ff[1];
      pipe_in[0].rho_a   = req_data.rho_alpha;
      pipe_in[0].rho_b   = req_data.rho_beta;
      pipe_in[0].energy  = req_data.prior_energy;
      pipe_in[0].grad_a  = req_data.prior_grad_alpha;
      pipe_in[0].grad_b  = req_data.prior_grad_beta;
      pipe_in[0].hess_aa = req_data.prior_hess_aa;
      pipe_in[0].hess_bb = req_data.prior_hess_bb;
      pipe_in[0].flag    = 1'b0;
      pipe_in[0].big_a   = 1'b0;
      pipe_in[0].big_b   = 1'b0;
      pipe_in[0].zero_a  = 1'b0;
      pipe_in[0].zero_b  = 1'b0;
      for (int k = 1; k < PIPE_DEPTH; k++) begin
         pipe_in[k]       = pipe_ff[k-1];
         pipe_in[k].valid = pipe_ff[k-1].valid && !reset;
      end

      if (do_ga) pipe_in[STAGE_GRAD].grad_a = ga_sat.value;
      if (do_gb) pipe_in[STAGE_GRAD].grad_b = gb_sat.value;
      pipe_in[STAGE_GRAD].flag   = pipe_ff[STAGE_GRAD-1].flag
                                 | (do_ga & ga_sat.clip) | (do_gb & gb_sat.clip);
      pipe_in[STAGE_GRAD].big_a  = big_sp[SPIN_A];
      pipe_in[STAGE_GRAD].big_b  = big_sp[SPIN_B];
      pipe_in[STAGE_GRAD].zero_a = zero_sp[SPIN_A];
      pipe_in[STAGE_GRAD].zero_b = zero_sp[SPIN_B];

      if (do_e) pipe_in[STAGE_ENERGY].energy = e_sat.value;
      pipe_in[STAGE_ENERGY].flag = pipe_ff[STAGE_ENERGY-1].flag | (do_e & e_sat.clip);

      if (do_ha) pipe_in[STAGE_HESS].hess_aa = ha_sat.value;
      if (do_hb) pipe_in[STAGE_HESS].hess_bb = hb_sat.value;
      pipe_in[STAGE_HESS].flag = pipe_ff[STAGE_HESS-1].flag
                               | (do_ha & ha_sat.clip) | (do_hb & hb_sat.clip);
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < PIPE_DEPTH; k++) begin
         pipe_ff[k] <= pipe_in[k];
      end
   end

   assign rsp_strobe              = pipe_ff[PIPE_DEPTH-1].valid;
   assign rsp_data.energy_out     = pipe_ff[PIPE_DEPTH-1].energy;
   assign rsp_data.grad_alpha_out = pipe_ff[PIPE_DEPTH-1].grad_a;
   assign rsp_data.grad_beta_out  = pipe_ff[PIPE_DEPTH-1].grad_b;
   assign rsp_data.hess_aa_out    = pipe_ff[PIPE_DEPTH-1].hess_aa;
   assign rsp_data.hess_bb_out    = pipe_ff[PIPE_DEPTH-1].hess_bb;
   assign rsp_data.saturated      = pipe_ff[PIPE_DEPTH-1].flag;

   // Every transferred point yields its result after the full pipeline depth.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##(PIPE_DEPTH) rsp_strobe)
      else $error("result missing after pipeline depth");

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_strobe)
      else $error("result strobe right after reset");

   // An energy point leaves the Hessian outputs as they came in.
   a_hess_pass: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && pipe_ff[PIPE_DEPTH-1].kind == lse_pkg::KIND_ENERGY
      |-> rsp_data.hess_aa_out == $past(req_data.prior_hess_aa, PIPE_DEPTH)
          && rsp_data.hess_bb_out == $past(req_data.prior_hess_bb, PIPE_DEPTH))
      else $error("Hessian changed on an energy point");

   // A selected spin with zero density in the Hessian raises the flag.
   a_zero_flag: assert property (@(posedge clock) disable iff (reset)
      pipe_ff[STAGE_HESS-1].valid && pipe_ff[STAGE_HESS-1].kind == lse_pkg::KIND_HESS
      && ((pipe_ff[STAGE_HESS-1].use_a && pipe_ff[STAGE_HESS-1].zero_a)
          || (pipe_ff[STAGE_HESS-1].use_b && pipe_ff[STAGE_HESS-1].zero_b))
      |=> rsp_strobe && rsp_data.saturated)
      else $error("zero density without saturated flag");

endmodule
